/* rtl/plcc_pkg.sv */
// ----------------------------------------------------------------------------
// plcc_pkg: shared types and constants for the charge curve block
// Command and status codes, field widths, divider request/response structs.
// ----------------------------------------------------------------------------
package plcc_pkg;
  localparam int EW = 24;
  localparam int TW = 24;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FEW      = 3'd1;
  localparam logic [2:0] ST_BAD_APP  = 3'd2;
  localparam logic [2:0] ST_BEYOND   = 3'd3;
  localparam logic [2:0] ST_DEP_LOW  = 3'd4;

  localparam int DIVW = 48;

  typedef struct packed {
    logic            start;
    logic [DIVW-1:0] num;
    logic [EW-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DIVW-1:0] quo;
  } div_rsp_t;
endpackage

/* rtl/plcc_div.sv */
// ----------------------------------------------------------------------------
// plcc_div: shared restoring divider
// One quotient bit per cycle, 48-bit dividend by 24-bit divisor.
// ----------------------------------------------------------------------------
module plcc_div (
  input  logic                clk,
  input  logic                rst,
  input  plcc_pkg::div_req_t  req,
  output plcc_pkg::div_rsp_t  rsp
);
  localparam int N  = plcc_pkg::DIVW;
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]            quo;
  logic [plcc_pkg::EW:0]   rem;
  logic [plcc_pkg::EW-1:0] den;
  logic [CW-1:0]           cnt;
  logic                    busy;
  logic                    done;
  logic [plcc_pkg::EW:0]   trial;
  logic [plcc_pkg::EW+1:0] sub;

  always_comb begin
    trial = {rem[plcc_pkg::EW-1:0], quo[N-1]};
    sub   = {1'b0, trial} - {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse after the last quotient bit
      done <= busy && !req.start && (cnt == CW'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        if (sub[plcc_pkg::EW+1]) begin
          rem <= trial;
          quo <= {quo[N-2:0], 1'b0};
        end else begin
          rem <= sub[plcc_pkg::EW:0];
          quo <= {quo[N-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
endmodule

/* rtl/plcc_table.sv */
// ----------------------------------------------------------------------------
// plcc_table: breakpoint memory
// Energy and time side by side, one write port, one registered read port.
// ----------------------------------------------------------------------------
module plcc_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic [plcc_pkg::EW+plcc_pkg::TW-1:0] wdata,
  input  logic [AW-1:0]                     raddr,
  output logic [plcc_pkg::EW+plcc_pkg::TW-1:0] rdata
);
  logic [plcc_pkg::EW+plcc_pkg::TW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/piecewise_linear_charge_curve.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_charge_curve: breakpoint table with linear interpolation
// Holds a monotone (energy, time) curve; queries give duration, rate, next bp.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                         | tuser
//  s_axis  | in  | point_energy, point_time, arrival_energy,  | cmd
//          |     | departure_energy (96 bits)                 |
//  m_axis  | out | duration, marginal_rate, rate_infinite,    | status
//          |     | next_breakpoint (80 bits, 7 pad)           |
//
// One beat in work at a time. Clear and the unused command go straight to the result;
// an append reads the last entry in S_APPW, skipped for the first point or a full table.
// A query scans the table, then runs three divisions in turn on the
// shared bit-serial divider; errors found before the divisions end it early.
// Reset empties the table (count to zero); the memory is not cleared.
// s_tready is low while an item is in work or its result waits in the output register.
module piecewise_linear_charge_curve #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // point_energy, point_time, arrival_e, departure_e
  input  logic [1:0]  s_tuser,  // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // duration, marginal_rate, rate_infinite, next_breakpoint
  output logic [2:0]  m_tuser   // status
);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = plcc_pkg::EW;
  localparam int DW = plcc_pkg::DIVW;

  localparam logic [3:0] S_IDLE = 4'd0, S_APP = 4'd1, S_APPW = 4'd2,
                         S_SCAN = 4'd3, S_DIVA = 4'd4, S_WA = 4'd5,
                         S_DIVD = 4'd6, S_WD = 4'd7, S_DIVR = 4'd8,
                         S_WR = 4'd9, S_OUT = 4'd10;

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic [EW-1:0] pe, pt, arr, dep;

  // memory access
  logic              we;
  logic [AW-1:0]     raddr;
  logic [2*EW-1:0]   rdata;
  logic [CW-1:0]     idx;       // entry being issued
  logic              rvalid;
  logic [CW-1:0]     ridx;      // entry arriving on rdata
  logic [EW-1:0]     pre_e, pre_t; // previous entry seen

  // segment captures: arrival (interp), departure, rate
  logic              fa, fd, fr, fn;
  logic [EW-1:0]     a_le, a_lt, a_re, a_rt;
  logic [EW-1:0]     d_le, d_lt, d_re, d_rt;
  logic [EW-1:0]     r_de, r_dt;
  logic [EW-1:0]     nbp, cap;
  logic [EW-1:0]     ta, td;

  logic [2:0]    o_status;
  logic [EW-1:0] o_dur, o_rate, o_nbp;
  logic          o_inf;

  plcc_pkg::div_req_t dreq;
  plcc_pkg::div_rsp_t drsp;

  plcc_table #(.DEPTH(MAX_POINTS), .AW(AW)) u_table (
    .clk(clk), .we(we), .waddr(count[AW-1:0]), .wdata({pt, pe}),
    .raddr(raddr), .rdata(rdata)
  );

  plcc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [EW-1:0] re_w, rt_w;
  assign re_w = rdata[EW-1:0];
  assign rt_w = rdata[2*EW-1:EW];

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign raddr    = idx[AW-1:0];

  always_comb begin
    we = (state == S_APP) && (count == '0 ? (pe == '0 && pt == '0) : 1'b0);
    if (state == S_APPW) we = !(pe < re_w || pt < rt_w);
  end

  // divider request
  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '1;
    unique case (state)
      S_DIVA: begin
        dreq.start = 1'b1;
        dreq.num   = DW'(arr - a_le) * DW'(a_rt - a_lt);
        dreq.den   = a_re - a_le;
      end
      S_DIVD: begin
        dreq.start = 1'b1;
        dreq.num   = DW'(dep - d_le) * DW'(d_rt - d_lt);
        dreq.den   = d_re - d_le;
      end
      S_DIVR: begin
        dreq.start = 1'b1;
        dreq.num   = DW'({r_de, 16'd0});
        dreq.den   = r_dt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
      rvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          pe  <= s_tdata[23:0];
          pt  <= s_tdata[47:24];
          arr <= s_tdata[71:48];
          dep <= s_tdata[95:72];
          o_status <= plcc_pkg::ST_OK;
          o_dur <= '0; o_rate <= '0; o_nbp <= '0; o_inf <= 1'b0;
          fa <= 1'b0; fd <= 1'b0; fr <= 1'b0; fn <= 1'b0;
          rvalid <= 1'b0;
          unique case (s_tuser)
            plcc_pkg::CMD_CLEAR: begin
              count <= '0;
              state <= S_OUT;
            end
            plcc_pkg::CMD_APPEND: begin
              idx   <= count - 1'b1;
              state <= S_APP;
            end
            plcc_pkg::CMD_QUERY: begin
              idx   <= '0;
              state <= S_SCAN;
            end
            default: state <= S_OUT;
          endcase
        end
        S_APP: begin
          if (count >= CW'(MAX_POINTS)) begin
            o_status <= plcc_pkg::ST_BAD_APP;
            state    <= S_OUT;
          end else if (count == '0) begin
            if (we) count <= count + 1'b1;
            else o_status <= plcc_pkg::ST_BAD_APP;
            state <= S_OUT;
          end else begin
            state <= S_APPW;
          end
        end
        S_APPW: begin
          if (we) count <= count + 1'b1;
          else o_status <= plcc_pkg::ST_BAD_APP;
          state <= S_OUT;
        end
        S_SCAN: begin
          if (count < CW'(2)) begin
            o_status <= plcc_pkg::ST_FEW;
            state    <= S_OUT;
          end else if (dep < arr) begin
            o_status <= plcc_pkg::ST_DEP_LOW;
            state    <= S_OUT;
          end else begin
            // idx reaches count with the last entry, so rvalid drops by itself
            if (idx < count) idx <= idx + 1'b1;
            rvalid <= (idx < count);
            ridx   <= idx;
            if (rvalid) begin
              pre_e <= re_w;
              pre_t <= rt_w;
              if (ridx != '0) begin
                if (!fa && arr <= re_w) begin
                  fa <= 1'b1; a_le <= pre_e; a_lt <= pre_t; a_re <= re_w; a_rt <= rt_w;
                end
                if (!fd && dep <= re_w) begin
                  fd <= 1'b1; d_le <= pre_e; d_lt <= pre_t; d_re <= re_w; d_rt <= rt_w;
                end
                if (!fr && arr < re_w) begin
                  fr <= 1'b1; r_de <= re_w - pre_e; r_dt <= rt_w - pre_t;
                end
                if (!fn && re_w > arr) begin
                  fn <= 1'b1; nbp <= re_w;
                end
              end
              if (ridx == count - 1'b1) begin
                cap <= re_w;
                if (arr > re_w || dep > re_w) begin
                  o_status <= plcc_pkg::ST_BEYOND;
                  state    <= S_OUT;
                end else begin
                  state <= S_DIVA;
                end
              end
            end
          end
        end
        S_DIVA: state <= S_WA;
        S_WA: if (drsp.done) begin
          ta    <= (a_re == a_le) ? a_lt : a_lt + drsp.quo[EW-1:0];
          state <= S_DIVD;
        end
        S_DIVD: state <= S_WD;
        S_WD: if (drsp.done) begin
          td    <= (d_re == d_le) ? d_lt : d_lt + drsp.quo[EW-1:0];
          state <= S_DIVR;
        end
        S_DIVR: state <= S_WR;
        S_WR: if (drsp.done) begin
          o_dur <= td - ta;
          o_nbp <= fn ? nbp : cap;
          if (arr < cap && fr) begin
            if (r_dt == '0) o_inf <= 1'b1;
            else if (drsp.quo[DW-1:EW] != '0) o_rate <= '1;
            else o_rate <= drsp.quo[EW-1:0];
          end
          state <= S_OUT;
        end
        S_OUT: if (!m_tvalid) begin
          m_tvalid <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {7'd0, o_nbp, o_inf, o_rate, o_dur};
  assign m_tuser = o_status;
endmodule

/* rtl/plcc_checker.sv */
// ----------------------------------------------------------------------------
// plcc_checker: port-level checks for the charge curve block
// Watches handshakes and result codes; bound to the top level.
// ----------------------------------------------------------------------------
module plcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [2:0]  m_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while result pending");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != plcc_pkg::ST_OK |-> m_tdata == '0)
    else $error("error result carries data");

  a_inf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[48] |-> m_tdata[47:24] == '0)
    else $error("infinite rate with nonzero rate");
endmodule

bind piecewise_linear_charge_curve plcc_checker u_plcc_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

/* dv/piecewise_linear_charge_curve_tb.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_charge_curve_tb: self-checking bench for the charge curve
// Directed table of curve builds and queries, then random curves and queries;
// every result beat is compared against a behavioral model of the table.
// ----------------------------------------------------------------------------
module piecewise_linear_charge_curve_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS      = 16;
  localparam int N_RANDOM  = 1900;
  localparam int CYC_LIMIT = 1500000;
  localparam logic [23:0] M24 = 24'hFFFFFF;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] duration;
    logic [23:0] rate;
    logic        rate_inf;
    logic [23:0] next_bp;
  } curve_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [23:0] pe, pt, arr, dep;
    logic        has_exp;    // expected status typed into the row
    logic [2:0]  exp_status;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;  // point_energy, point_time, arrival_e, departure_e
  logic [1:0]  s_tuser = '0;  // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;       // duration, marginal_rate, rate_infinite, next_breakpoint
  logic [2:0]  m_tuser;       // status

  piecewise_linear_charge_curve #(.MAX_POINTS(NPTS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model copy of the curve table
  logic [23:0] tbl_e [NPTS];
  logic [23:0] tbl_t [NPTS];
  int          tbl_n;

  curve_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic [23:0] time_at(input logic [23:0] e);
    logic [63:0] de, q;
    for (int i = 1; i < tbl_n; i++) begin
      if (e <= tbl_e[i]) begin
        de = 64'(tbl_e[i] - tbl_e[i-1]);
        if (de == 0) return tbl_t[i-1];
        q = (64'(e - tbl_e[i-1]) * 64'(tbl_t[i] - tbl_t[i-1])) / de;
        return tbl_t[i-1] + q[23:0];
      end
    end
    return tbl_t[tbl_n-1];
  endfunction

  // advances the model table and gives the result beat for one command
  function automatic curve_result_t curve_step(input logic [1:0] cmd, input logic [23:0] pe,
      input logic [23:0] pt, input logic [23:0] arr, input logic [23:0] dep);
    curve_result_t r;
    logic [23:0] cap;
    logic [63:0] dt, de, q;
    logic bad;
    r = '0;
    case (cmd)
      plcc_pkg::CMD_CLEAR: tbl_n = 0;
      plcc_pkg::CMD_APPEND: begin
        if (tbl_n >= NPTS) bad = 1'b1;
        else if (tbl_n == 0) bad = (pe != 0) || (pt != 0);
        else bad = (pe < tbl_e[tbl_n-1]) || (pt < tbl_t[tbl_n-1]);
        if (bad) r.status = plcc_pkg::ST_BAD_APP;
        else begin
          tbl_e[tbl_n] = pe;
          tbl_t[tbl_n] = pt;
          tbl_n++;
        end
      end
      plcc_pkg::CMD_QUERY: begin
        if (tbl_n < 2) r.status = plcc_pkg::ST_FEW;
        else if (dep < arr) r.status = plcc_pkg::ST_DEP_LOW;
        else begin
          cap = tbl_e[tbl_n-1];
          if (arr > cap || dep > cap) r.status = plcc_pkg::ST_BEYOND;
          else begin
            r.duration = time_at(dep) - time_at(arr);
            if (arr < cap) begin
              for (int i = 1; i < tbl_n; i++) begin
                if (arr < tbl_e[i]) begin
                  dt = 64'(tbl_t[i] - tbl_t[i-1]);
                  de = 64'(tbl_e[i] - tbl_e[i-1]);
                  if (dt == 0) r.rate_inf = 1'b1;
                  else begin
                    q = (de << 16) / dt;
                    r.rate = (q > 64'(M24)) ? M24 : q[23:0];
                  end
                  break;
                end
              end
            end
            r.next_bp = cap;
            for (int i = 1; i < tbl_n; i++) begin
              if (tbl_e[i] > arr) begin
                r.next_bp = tbl_e[i];
                break;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // sender: one beat, with a random gap before it while a burst is over
  int burst_left = 0;
  task automatic send_beat(input logic [1:0] cmd, input logic [23:0] pe, input logic [23:0] pt,
                           input logic [23:0] arr, input logic [23:0] dep);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {dep, arr, pt, pe};
    pending_results = {pending_results, curve_step(cmd, pe, pt, arr, dep)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // random energy, biased toward breakpoints and the table ends
  function automatic logic [23:0] pick_energy();
    int k;
    k = $urandom_range(0, 9);
    if (tbl_n == 0 || k == 0) return 24'($urandom);
    if (k <= 3) return tbl_e[$urandom_range(0, tbl_n-1)];
    if (k == 4) return 24'(tbl_e[tbl_n-1] + $urandom_range(0, 2));
    return 24'($urandom_range(0, tbl_e[tbl_n-1]));
  endfunction

  // receiver: stall pattern of its own, with quiet stretches
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (cycles % 3000 < 600) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  // result checker
  always @(posedge clk) begin
    curve_result_t want;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 24'(m_tuser), '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.status) report_mismatch("status", 24'(m_tuser), 24'(want.status));
        if (m_tdata[23:0] != want.duration)
          report_mismatch("duration", m_tdata[23:0], want.duration);
        if (m_tdata[47:24] != want.rate) report_mismatch("rate", m_tdata[47:24], want.rate);
        if (m_tdata[72:49] != want.next_bp)
          report_mismatch("next_bp", m_tdata[72:49], want.next_bp);
        if (m_tdata[48] != want.rate_inf)
          report_mismatch("rate_inf", 24'(m_tdata[48]), 24'(want.rate_inf));
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycles >= CYC_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // directed rows; status typed in where obvious
  stim_row_t rows[$];
  task automatic add_row(input logic [1:0] c, input logic [23:0] pe, input logic [23:0] pt,
                         input logic [23:0] a, input logic [23:0] d,
                         input logic he, input logic [2:0] es);
    stim_row_t r;
    r = '{c, pe, pt, a, d, he, es};
    rows = {rows, r};
  endtask

  initial begin
    curve_result_t got_exp;
    logic [23:0] e, t;
    int n;
    int gap;
    tbl_n = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table
    add_row(plcc_pkg::CMD_QUERY,  0, 0, 0, 0, 1, plcc_pkg::ST_FEW);
    // first point not origin
    add_row(plcc_pkg::CMD_APPEND, 5, 0, 0, 0, 1, plcc_pkg::ST_BAD_APP);
    add_row(plcc_pkg::CMD_APPEND, 0, 0, 0, 0, 1, plcc_pkg::ST_OK);
    // one point
    add_row(plcc_pkg::CMD_QUERY,  0, 0, 0, 0, 1, plcc_pkg::ST_FEW);
    add_row(plcc_pkg::CMD_APPEND, 100, 1000, 0, 0, 1, plcc_pkg::ST_OK);
    // vertical segment
    add_row(plcc_pkg::CMD_APPEND, 100, 2000, 0, 0, 1, plcc_pkg::ST_OK);
    // flat segment in time
    add_row(plcc_pkg::CMD_APPEND, 200, 2000, 0, 0, 1, plcc_pkg::ST_OK);
    // energy falls back
    add_row(plcc_pkg::CMD_APPEND, 150, 3000, 0, 0, 1, plcc_pkg::ST_BAD_APP);
    // time falls back
    add_row(plcc_pkg::CMD_APPEND, 300, 1999, 0, 0, 1, plcc_pkg::ST_BAD_APP);
    // extreme point
    add_row(plcc_pkg::CMD_APPEND, M24, M24, 0, 0, 1, plcc_pkg::ST_OK);
    add_row(plcc_pkg::CMD_QUERY,  0, 0, 50, 10, 1, plcc_pkg::ST_DEP_LOW);
    add_row(plcc_pkg::CMD_QUERY,  0, 0, 0, 0, 0, plcc_pkg::ST_OK);
    add_row(plcc_pkg::CMD_QUERY,  0, 0, 0, M24, 0, plcc_pkg::ST_OK);
    // at vertical
    add_row(plcc_pkg::CMD_QUERY,  0, 0, 100, 150, 0, plcc_pkg::ST_OK);
    // rate infinite on the flat segment
    add_row(plcc_pkg::CMD_QUERY,  0, 0, 150, 200, 0, plcc_pkg::ST_OK);
    // arrival at capacity
    add_row(plcc_pkg::CMD_QUERY,  0, 0, M24, M24, 0, plcc_pkg::ST_OK);
    add_row(CMD_UNUSED, M24, M24, M24, M24, 0, plcc_pkg::ST_OK);
    add_row(plcc_pkg::CMD_CLEAR,  0, 0, 0, 0, 1, plcc_pkg::ST_OK);
    add_row(plcc_pkg::CMD_APPEND, 0, 0, 0, 0, 1, plcc_pkg::ST_OK);
    add_row(plcc_pkg::CMD_APPEND, 10, 0, 0, 0, 1, plcc_pkg::ST_OK);
    add_row(plcc_pkg::CMD_QUERY,  0, 0, 11, 11, 1, plcc_pkg::ST_BEYOND);
    add_row(plcc_pkg::CMD_QUERY,  0, 0, 3, 7, 0, plcc_pkg::ST_OK);

    foreach (rows[i]) begin
      got_exp = curve_step(rows[i].cmd, rows[i].pe, rows[i].pt, rows[i].arr, rows[i].dep);
      if (rows[i].has_exp && got_exp.status != rows[i].exp_status)
        report_mismatch("table status", 24'(got_exp.status), 24'(rows[i].exp_status));
      pending_results = {pending_results, got_exp};
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 20);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      s_tvalid <= 1'b1;
      s_tuser  <= rows[i].cmd;
      s_tdata  <= {rows[i].dep, rows[i].arr, rows[i].pt, rows[i].pe};
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    drain_results();  // sender holds off until every result is in

    // random: mostly build a curve then query it, some noise
    n = 0;
    while (n < N_RANDOM) begin
      send_beat(plcc_pkg::CMD_CLEAR, 24'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom));
      n++;
      e = 0; t = 0;
      send_beat(plcc_pkg::CMD_APPEND, 0, 0, 24'($urandom), 24'($urandom));
      repeat ($urandom_range(1, 17)) begin
        case ($urandom_range(0, 9))
          0: begin e = 24'(e + $urandom_range(0, 3)); end  // near flat in time / repeat
          1: begin e = 24'($urandom); t = 24'($urandom); end // broken or huge
          default: begin
            e = 24'(e + $urandom_range(0, ($urandom_range(0, 4) == 0) ? 24'h3FFFFF : 4000));
            t = 24'(t + $urandom_range(0, ($urandom_range(0, 4) == 0) ? 24'h3FFFFF : 4000));
          end
        endcase
        if ($urandom_range(0, 7) == 0)
          send_beat(plcc_pkg::CMD_APPEND, 24'($urandom), 24'($urandom), 0, 0);
        else send_beat(plcc_pkg::CMD_APPEND, e, t, 24'($urandom), 24'($urandom));
        n++;
      end
      repeat ($urandom_range(2, 10)) begin
        e = pick_energy();
        t = pick_energy();
        if ($urandom_range(0, 5) == 0)
          send_beat(2'($urandom_range(0, 3)), 24'($urandom), 24'($urandom),
                    24'($urandom), 24'($urandom));
        else if (e <= t)
          send_beat(plcc_pkg::CMD_QUERY, 24'($urandom), 24'($urandom), e, t);
        else send_beat(plcc_pkg::CMD_QUERY, 24'($urandom), 24'($urandom), t, e);
        n++;
      end
    end

    drain_results();
    repeat (400) @(posedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
